/* sv/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Shared widths, request codes, status codes and the result record of the
// array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  // payload widths of the channels
  localparam int OP_BITS   = 4;
  localparam int POS_BITS  = 6;
  localparam int VAL_BITS  = 32;
  localparam int IDX_BITS  = 5;
  localparam int LEN_BITS  = 6;
  localparam int STAT_BITS = 2;
  localparam int CAP_BITS  = 6;

  // defaults of the top level parameters
  localparam int DEPTH_DEF     = 32;
  localparam int DATA_BITS_DEF = 32;

  // capacity after reset
  localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd32;

  // request codes
  localparam logic [OP_BITS-1:0] OP_APPEND       = 4'd0;
  localparam logic [OP_BITS-1:0] OP_PREPEND      = 4'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT       = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DELETE_AT    = 4'd3;
  localparam logic [OP_BITS-1:0] OP_REMOVE_FIRST = 4'd4;
  localparam logic [OP_BITS-1:0] OP_REMOVE_LAST  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_READ_AT      = 4'd6;
  localparam logic [OP_BITS-1:0] OP_FIND_FIRST   = 4'd7;
  localparam logic [OP_BITS-1:0] OP_FIND_LAST    = 4'd8;
  localparam logic [OP_BITS-1:0] OP_CHANGE_AT    = 4'd9;
  localparam logic [OP_BITS-1:0] OP_REPLACE_ALL  = 4'd10;
  localparam logic [OP_BITS-1:0] OP_DELETE_ALL   = 4'd11;
  localparam logic [OP_BITS-1:0] OP_CLEAR        = 4'd12;
  localparam logic [OP_BITS-1:0] OP_FILL         = 4'd13;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_BAD   = 2'd3;

  // one result item
  typedef struct packed {
    logic                 ok;
    logic [STAT_BITS-1:0] status;
    logic [VAL_BITS-1:0]  read_value;
    logic [IDX_BITS-1:0]  found_index;
    logic                 found;
    logic [LEN_BITS-1:0]  length;
    logic                 empty_res;
    logic                 full_res;
  } rsp_t;

endpackage

/* sv/ale_if.sv */
// ----------------------------------------------------------------------------
// ale_if
// Valid/ready channels of the array list engine: request and result.
// ----------------------------------------------------------------------------

// request channel
interface ale_req_if;
  logic                          valid;
  logic                          ready;
  logic [ale_pkg::OP_BITS-1:0]   op;
  logic [ale_pkg::POS_BITS-1:0]  position;
  logic [ale_pkg::VAL_BITS-1:0]  value;
  logic [ale_pkg::VAL_BITS-1:0]  replacement;

  modport source (output valid, op, position, value, replacement, input ready);
  modport sink   (input valid, op, position, value, replacement, output ready);
endinterface

// result channel
interface ale_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [ale_pkg::STAT_BITS-1:0] status;
  logic [ale_pkg::VAL_BITS-1:0]  read_value;
  logic [ale_pkg::IDX_BITS-1:0]  found_index;
  logic                          found;
  logic [ale_pkg::LEN_BITS-1:0]  length;
  logic                          empty_res;
  logic                          full_res;

  modport source (output valid, ok, status, read_value, found_index, found, length,
                  empty_res, full_res, input ready);
  modport sink   (input valid, ok, status, read_value, found_index, found, length,
                  empty_res, full_res, output ready);
endinterface

/* sv/ale_store.sv */
// ----------------------------------------------------------------------------
// ale_store
// Entry memory of the list: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ale_store #(
  parameter int DEPTH     = ale_pkg::DEPTH_DEF,
  parameter int DATA_BITS = ale_pkg::DATA_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_BITS-1:0]       wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_BITS-1:0]       rdata
);
  import ale_pkg::*;

  logic [DATA_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ale_ctrl.sv */
// ----------------------------------------------------------------------------
// ale_ctrl
// Request sequencer: checks a request, walks the entry memory one entry a
// cycle through a shared compare and address unit, then forms the result.
// ----------------------------------------------------------------------------
module ale_ctrl #(
  parameter int DEPTH     = ale_pkg::DEPTH_DEF,
  parameter int DATA_BITS = ale_pkg::DATA_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [ale_pkg::OP_BITS-1:0]    req_op,
  input  logic [ale_pkg::POS_BITS-1:0]   req_position,
  input  logic [ale_pkg::VAL_BITS-1:0]   req_value,
  input  logic [ale_pkg::VAL_BITS-1:0]   req_replacement,
  // configured capacity
  input  logic [ale_pkg::CAP_BITS-1:0]   cap,
  // result side
  input  logic                           rsp_free,
  output logic                           done,
  output ale_pkg::rsp_t                  result,
  // entry memory
  output logic                           mem_we,
  output logic [$clog2(DEPTH)-1:0]       mem_waddr,
  output logic [DATA_BITS-1:0]           mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(DEPTH)-1:0]       mem_raddr,
  input  logic [DATA_BITS-1:0]           mem_rdata
);
  import ale_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_WALK  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // control registers
  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            pend, pend_next;
  // request and walk registers
  logic [OP_BITS-1:0]   op_r, op_r_next;
  logic [PW-1:0]        pos_r, pos_r_next;
  logic [DATA_BITS-1:0] key_r, key_r_next;
  logic [DATA_BITS-1:0] rep_r, rep_r_next;
  logic [CW-1:0]        rem, rem_next;
  logic [AW-1:0]        rptr, rptr_next;
  logic                 up, up_next;
  logic [AW-1:0]        pend_idx, pend_idx_next;
  logic [CW-1:0]        wptr, wptr_next;
  logic                 hit, hit_next;
  logic [AW-1:0]        fidx, fidx_next;
  logic [DATA_BITS-1:0] rd_word, rd_word_next;
  logic                 err, err_next;
  logic [STAT_BITS-1:0] err_st, err_st_next;

  // helper values
  logic [CW-1:0]                  eff_cap;
  logic [PW-1:0]                  count_p;
  logic [PW-1:0]                  tpos;
  logic                           full_now;
  logic                           empty_now;
  logic                           match;
  logic                           issue;
  logic                           is_ins;
  logic                           is_del;
  logic                           is_find;
  logic [DATA_BITS+VAL_BITS-1:0]  key_ext;
  logic [DATA_BITS+VAL_BITS-1:0]  rep_ext;
  logic signed [DATA_BITS+VAL_BITS-1:0] rd_ext;
  logic [AW+IDX_BITS-1:0]         fidx_ext;
  logic [CW+LEN_BITS-1:0]         len_ext;

  // capacity saturated to 1 .. DEPTH
  always_comb begin
    if (cap == '0) begin
      eff_cap = CW'(1);
    end else if (PW'(cap) > PW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap);
    end
  end

  // request words sign-extended or cut to the stored word width
  assign key_ext = {{DATA_BITS{req_value[VAL_BITS-1]}}, req_value};
  assign rep_ext = {{DATA_BITS{req_replacement[VAL_BITS-1]}}, req_replacement};

  assign count_p   = PW'(count);
  assign full_now  = count >= eff_cap;
  assign empty_now = count == '0;
  assign is_ins    = (op_r == OP_APPEND) || (op_r == OP_PREPEND) || (op_r == OP_INSERT);
  assign is_del    = (op_r == OP_DELETE_AT) || (op_r == OP_REMOVE_FIRST) ||
                     (op_r == OP_REMOVE_LAST);
  assign is_find   = (op_r == OP_FIND_FIRST) || (op_r == OP_FIND_LAST);

  // shared compare unit
  assign match = pend && (mem_rdata == key_r);
  assign issue = (state == S_WALK) && (rem != '0);

  assign req_ready = state == S_IDLE;
  assign mem_raddr = rptr;
  assign mem_re    = issue && (op_r != OP_FILL);

  // sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    pend_next     = 1'b0;
    op_r_next     = op_r;
    pos_r_next    = pos_r;
    key_r_next    = key_r;
    rep_r_next    = rep_r;
    rem_next      = rem;
    rptr_next     = rptr;
    up_next       = up;
    pend_idx_next = rptr;
    wptr_next     = wptr;
    hit_next      = hit;
    fidx_next     = fidx;
    rd_word_next  = rd_word;
    err_next      = err;
    err_st_next   = err_st;
    tpos          = pos_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = key_r;
    done          = 1'b0;

    case (state)
      // take one request
      S_IDLE: begin
        if (req_valid) begin
          op_r_next  = req_op;
          pos_r_next = PW'(req_position);
          key_r_next = key_ext[DATA_BITS-1:0];
          rep_r_next = rep_ext[DATA_BITS-1:0];
          state_next = S_CHECK;
        end
      end

      // decide errors and set up the walk
      S_CHECK: begin
        err_next    = 1'b0;
        err_st_next = ST_OK;
        hit_next    = 1'b0;
        wptr_next   = '0;
        rem_next    = '0;
        rptr_next   = '0;
        up_next     = 1'b1;
        case (op_r)
          OP_APPEND, OP_PREPEND, OP_INSERT: begin
            if (op_r == OP_APPEND) begin
              tpos = count_p;
            end else if (op_r == OP_PREPEND) begin
              tpos = '0;
            end else begin
              tpos = pos_r;
            end
            pos_r_next = tpos;
            if (full_now) begin
              err_next    = 1'b1;
              err_st_next = ST_FULL;
            end else if (tpos > count_p) begin
              err_next    = 1'b1;
              err_st_next = ST_BAD;
            end else begin
              // shift up from the last entry down to the slot
              rem_next  = CW'(count_p - tpos);
              rptr_next = AW'(count - CW'(1));
              up_next   = 1'b0;
            end
          end
          OP_DELETE_AT, OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_READ_AT, OP_CHANGE_AT: begin
            if (op_r == OP_REMOVE_FIRST) begin
              tpos = '0;
            end else if (op_r == OP_REMOVE_LAST) begin
              tpos = count_p - PW'(1);
            end else begin
              tpos = pos_r;
            end
            pos_r_next = tpos;
            if (empty_now) begin
              err_next    = 1'b1;
              err_st_next = ST_EMPTY;
            end else if (tpos >= count_p) begin
              err_next    = 1'b1;
              err_st_next = ST_BAD;
            end else if (op_r == OP_READ_AT) begin
              rem_next  = CW'(1);
              rptr_next = AW'(tpos);
            end else if (op_r != OP_CHANGE_AT) begin
              // shift down the entries above the slot
              rem_next  = CW'(count_p - tpos - PW'(1));
              rptr_next = AW'(tpos + PW'(1));
            end
          end
          OP_FIND_FIRST, OP_FIND_LAST, OP_REPLACE_ALL, OP_DELETE_ALL: begin
            if (empty_now) begin
              err_next    = 1'b1;
              err_st_next = ST_EMPTY;
            end else begin
              rem_next = count;
              if (op_r == OP_FIND_LAST) begin
                rptr_next = AW'(count - CW'(1));
                up_next   = 1'b0;
              end
            end
          end
          OP_CLEAR: begin
            rem_next = '0;
          end
          OP_FILL: begin
            rem_next = eff_cap;
          end
          default: begin
            err_next    = 1'b1;
            err_st_next = ST_BAD;
          end
        endcase
        state_next = err_next ? S_FIN : S_WALK;
      end

      // one entry a cycle: read ahead, act on the entry read last cycle
      S_WALK: begin
        if (issue) begin
          rem_next  = rem - CW'(1);
          rptr_next = up ? rptr + AW'(1) : rptr - AW'(1);
          pend_next = op_r != OP_FILL;
        end
        if (op_r == OP_FILL) begin
          if (issue) begin
            mem_we    = 1'b1;
            mem_waddr = rptr;
            mem_wdata = key_r;
          end
        end else if (pend) begin
          if (is_ins) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx + AW'(1);
            mem_wdata = mem_rdata;
          end else if (is_del) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx - AW'(1);
            mem_wdata = mem_rdata;
          end else if (op_r == OP_READ_AT) begin
            rd_word_next = mem_rdata;
          end else if (is_find) begin
            if (match) begin
              hit_next  = 1'b1;
              fidx_next = pend_idx;
              rem_next  = '0;
              pend_next = 1'b0;
            end
          end else if (op_r == OP_REPLACE_ALL) begin
            if (match) begin
              hit_next  = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = pend_idx;
              mem_wdata = rep_r;
            end
          end else if (op_r == OP_DELETE_ALL) begin
            if (match) begin
              hit_next = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(wptr);
              mem_wdata = mem_rdata;
              wptr_next = wptr + CW'(1);
            end
          end
        end
        if (rem == '0 && !pend) begin
          state_next = S_FIN;
        end
      end

      // final write, length update, hand over the result
      S_FIN: begin
        if (rsp_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
          if (!err) begin
            if (is_ins || op_r == OP_CHANGE_AT) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
              mem_wdata = key_r;
            end
            if (is_ins) begin
              count_next = count + CW'(1);
            end else if (is_del) begin
              count_next = count - CW'(1);
            end else if (op_r == OP_DELETE_ALL) begin
              count_next = wptr;
            end else if (op_r == OP_CLEAR) begin
              count_next = '0;
            end else if (op_r == OP_FILL) begin
              count_next = eff_cap;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result fields
  assign rd_ext   = (DATA_BITS + VAL_BITS)'($signed(rd_word));
  assign fidx_ext = (AW + IDX_BITS)'(fidx);
  assign len_ext  = (CW + LEN_BITS)'(count_next);

  always_comb begin
    result.ok          = 1'b0;
    result.status      = ST_OK;
    result.read_value  = '0;
    result.found_index = '0;
    result.found       = 1'b0;
    result.length      = len_ext[LEN_BITS-1:0];
    result.empty_res   = count_next == '0;
    result.full_res    = count_next >= eff_cap;
    if (err) begin
      result.status = err_st;
    end else if (is_find || op_r == OP_REPLACE_ALL || op_r == OP_DELETE_ALL) begin
      result.ok     = hit;
      result.status = hit ? ST_OK : ST_BAD;
      if (is_find && hit) begin
        result.found       = 1'b1;
        result.found_index = fidx_ext[IDX_BITS-1:0];
      end
    end else begin
      result.ok = 1'b1;
      if (op_r == OP_READ_AT) begin
        result.read_value = rd_ext[VAL_BITS-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // request and walk payload
  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    pos_r    <= pos_r_next;
    key_r    <= key_r_next;
    rep_r    <= rep_r_next;
    rem      <= rem_next;
    rptr     <= rptr_next;
    up       <= up_next;
    pend_idx <= pend_idx_next;
    wptr     <= wptr_next;
    hit      <= hit_next;
    fidx     <= fidx_next;
    rd_word  <= rd_word_next;
    err      <= err_next;
    err_st   <= err_st_next;
  end

  // list never grows past the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond store depth");

  // memory writes only while walking or finishing
  a_we_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_WALK || state == S_FIN))
    else $error("memory write outside walk");

  // a pending read only lives inside the walk
  a_pend_walk: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == S_WALK)
    else $error("pending read outside walk");

  // a finished walk moves on to the finish step
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && rem == '0 && !pend) |=> state == S_FIN)
    else $error("walk did not end");

  // after a result the sequencer is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_IDLE)
    else $error("not idle after result");

endmodule

/* sv/array_list_engine_top.sv */
// ----------------------------------------------------------------------------
// array_list_engine_top
// Packed list of signed words with request and result channels and a
// capacity register.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result item. From acceptance
// until its result is offered, a request goes through the check step, a walk
// that handles each entry it touches, with a trailing step for the last read
// when the walk reads memory, and the finish step, which waits for the result
// register to be free. Insert, append and prepend touch the entries from the
// slot to the end, deletes the entries above the slot, finds stop at the
// match, replace_all and delete_all touch every entry, fill writes capacity
// slots; read_at touches one, change_at and clear none. A refused request
// skips the walk. The next request can be taken in the cycle after a result
// is formed. The walk handles a single entry at a time over the entry
// memory, with one read and one write port. No clearing pass is needed after
// reset; a new request is taken while the last result waits.
// ----------------------------------------------------------------------------
module array_list_engine_top #(
  parameter int DEPTH     = ale_pkg::DEPTH_DEF,
  parameter int DATA_BITS = ale_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ale_req_if.sink                       req,
  ale_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [ale_pkg::CAP_BITS-1:0]  cfg_data
);
  import ale_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CAP_BITS-1:0]  cap;
  logic                 rsp_valid;
  rsp_t                 rsp_reg;
  rsp_t                 result;
  logic                 done;
  logic                 rsp_free;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DATA_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [DATA_BITS-1:0] mem_rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // result register
  assign rsp_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_reg <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_reg.ok;
  assign rsp.status      = rsp_reg.status;
  assign rsp.read_value  = rsp_reg.read_value;
  assign rsp.found_index = rsp_reg.found_index;
  assign rsp.found       = rsp_reg.found;
  assign rsp.length      = rsp_reg.length;
  assign rsp.empty_res   = rsp_reg.empty_res;
  assign rsp.full_res    = rsp_reg.full_res;

  // sequencer
  ale_ctrl #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_op          (req.op),
    .req_position    (req.position),
    .req_value       (req.value),
    .req_replacement (req.replacement),
    .cap             (cap),
    .rsp_free        (rsp_free),
    .done            (done),
    .result          (result),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  // entry memory
  ale_store #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* sim/ale_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ale_list_checker
// Watches the request, result and capacity ports of the array list engine,
// keeps its own copy of the list, works out the result of every accepted
// request and compares each accepted result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module ale_list_checker #(
  parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ale_req_if                           req,
  ale_rsp_if                           rsp,
  input  logic                         cfg_we,
  input  logic [ale_pkg::CAP_BITS-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending,
  output int                           result_count
);
  import ale_pkg::*;

  // shadow list state
  logic [VAL_BITS-1:0] slot_word [DEPTH];
  int                  list_len;
  logic [CAP_BITS-1:0] cap_setting;

  // results worked out but not yet seen
  rsp_t awaited[$];
  int   mismatches;
  int   results_seen;

  task automatic report_failure(input string msg);
    $display("[%0t] list check: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [VAL_BITS-1:0] got,
                             input logic [VAL_BITS-1:0] want);
    if (got !== want) begin
      report_failure($sformatf("result %0d field %s got %0h, want %0h",
                               results_seen, name, got, want));
    end
  endtask

  // apply one request to the shadow list and return its result
  function automatic rsp_t apply_list_request(input logic [OP_BITS-1:0] op,
                                              input logic [POS_BITS-1:0] pos_in,
                                              input logic [VAL_BITS-1:0] val,
                                              input logic [VAL_BITS-1:0] rep);
    rsp_t r;
    int   eff;
    int   p;
    int   i;
    int   j;
    bit   is_full;
    bit   is_empty;
    bit   hit;
    r        = '0;
    eff      = (cap_setting == 0) ? 1 :
               (int'(cap_setting) > DEPTH) ? DEPTH : int'(cap_setting);
    is_full  = list_len >= eff;
    is_empty = list_len == 0;
    hit      = 1'b0;
    case (op)
      OP_APPEND, OP_PREPEND, OP_INSERT: begin
        p = (op == OP_APPEND) ? list_len : (op == OP_PREPEND) ? 0 : int'(pos_in);
        // full is reported ahead of a bad position
        if (is_full) begin
          r.status = ST_FULL;
        end else if (p > list_len) begin
          r.status = ST_BAD;
        end else begin
          for (i = list_len; i > p; i--) slot_word[i] = slot_word[i-1];
          slot_word[p] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE_AT, OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_READ_AT, OP_CHANGE_AT: begin
        p = int'(pos_in);
        if (op == OP_REMOVE_FIRST) p = 0;
        if (op == OP_REMOVE_LAST) p = is_empty ? 0 : list_len - 1;
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_BAD;
        end else begin
          r.ok = 1'b1;
          if (op == OP_READ_AT) begin
            r.read_value = slot_word[p];
          end else if (op == OP_CHANGE_AT) begin
            slot_word[p] = val;
          end else begin
            // later entries shift down, freed slot goes to zero
            for (i = p; i < list_len - 1; i++) slot_word[i] = slot_word[i+1];
            slot_word[list_len-1] = '0;
            list_len--;
          end
        end
      end
      OP_FIND_FIRST, OP_FIND_LAST: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_BAD;
          for (i = 0; i < list_len && !hit; i++) begin
            j = (op == OP_FIND_FIRST) ? i : list_len - 1 - i;
            if (slot_word[j] == val) begin
              hit           = 1'b1;
              r.ok          = 1'b1;
              r.status      = ST_OK;
              r.found       = 1'b1;
              r.found_index = j[IDX_BITS-1:0];
            end
          end
        end
      end
      OP_REPLACE_ALL: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < list_len; i++) begin
            if (slot_word[i] == val) begin
              slot_word[i] = rep;
              hit          = 1'b1;
            end
          end
          if (hit) r.ok = 1'b1;
          else r.status = ST_BAD;
        end
      end
      OP_DELETE_ALL: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          // compact the survivors, zero the tail
          j = 0;
          for (i = 0; i < list_len; i++) begin
            if (slot_word[i] != val) begin
              slot_word[j] = slot_word[i];
              j++;
            end
          end
          hit = j != list_len;
          for (i = j; i < list_len; i++) slot_word[i] = '0;
          list_len = j;
          if (hit) r.ok = 1'b1;
          else r.status = ST_BAD;
        end
      end
      OP_CLEAR: begin
        foreach (slot_word[k]) slot_word[k] = '0;
        list_len = 0;
        r.ok     = 1'b1;
      end
      OP_FILL: begin
        for (i = 0; i < eff; i++) slot_word[i] = val;
        list_len = eff;
        r.ok     = 1'b1;
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    r.length    = list_len[LEN_BITS-1:0];
    r.empty_res = list_len == 0;
    r.full_res  = list_len >= eff;
    return r;
  endfunction

  // compare results, predict requests, track the capacity register
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (slot_word[k]) slot_word[k] = '0;
      list_len    = 0;
      cap_setting = CAP_RESET;
      awaited.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no request outstanding",
                                   results_seen));
        end else begin
          want = awaited.pop_front();
          check_field("ok", VAL_BITS'(rsp.ok), VAL_BITS'(want.ok));
          check_field("status", VAL_BITS'(rsp.status), VAL_BITS'(want.status));
          check_field("read_value", rsp.read_value, want.read_value);
          check_field("found_index", VAL_BITS'(rsp.found_index),
                      VAL_BITS'(want.found_index));
          check_field("found", VAL_BITS'(rsp.found), VAL_BITS'(want.found));
          check_field("length", VAL_BITS'(rsp.length), VAL_BITS'(want.length));
          check_field("empty_res", VAL_BITS'(rsp.empty_res), VAL_BITS'(want.empty_res));
          check_field("full_res", VAL_BITS'(rsp.full_res), VAL_BITS'(want.full_res));
        end
        results_seen++;
      end
      if (req.valid && req.ready) begin
        awaited.push_back(apply_list_request(req.op, req.position, req.value,
                                             req.replacement));
      end
      if (cfg_we) cap_setting = cfg_data;
    end
    pending      <= awaited.size();
    fail_count   <= mismatches;
    result_count <= results_seen;
  end

endmodule

/* sim/array_list_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_engine_top_tb
// Drives the array list engine with a directed list of edge cases and then
// random request mixes over a range of capacities, with random gaps on both
// channels, long result stalls and drained pauses; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module array_list_engine_top_tb;
  import ale_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD    = 160;
  localparam int END_CYCLES   = 40;

  // codes with no operation behind them
  localparam logic [OP_BITS-1:0] OP_SPARE_A = OP_FILL + 4'd1;
  localparam logic [OP_BITS-1:0] OP_SPARE_B = OP_FILL + 4'd2;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_data;

  ale_req_if req_ch();
  ale_rsp_if rsp_ch();

  int fail_count;
  int pending;
  int result_count;

  bit idle_on;
  bit hold_long;
  int cap_now;
  int items_sent;
  int cfg_writes;
  int holds_done;

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  array_list_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  ale_list_checker list_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // offer one request after a random gap and wait for it to be taken
  task automatic send_request(input logic [OP_BITS-1:0] op,
                              input logic [POS_BITS-1:0] pos,
                              input logic [VAL_BITS-1:0] val,
                              input logic [VAL_BITS-1:0] rep);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 3)) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.position    <= pos;
    req_ch.value       <= val;
    req_ch.replacement <= rep;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v[CAP_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_now  = (v > DEPTH_DEF) ? DEPTH_DEF : v;
    cfg_writes++;
  endtask

  // values mostly from a small pool so that searches hit
  function automatic logic [VAL_BITS-1:0] pick_value();
    int roll;
    int small_v;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      small_v = int'($urandom_range(0, 4)) - 2;
      return small_v;
    end
    if (roll < 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random_item();
    int                 roll;
    int                 pos_pick;
    logic [OP_BITS-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 14)      op = OP_APPEND;
    else if (roll < 24) op = OP_PREPEND;
    else if (roll < 38) op = OP_INSERT;
    else if (roll < 46) op = OP_DELETE_AT;
    else if (roll < 51) op = OP_REMOVE_FIRST;
    else if (roll < 56) op = OP_REMOVE_LAST;
    else if (roll < 66) op = OP_READ_AT;
    else if (roll < 72) op = OP_FIND_FIRST;
    else if (roll < 78) op = OP_FIND_LAST;
    else if (roll < 85) op = OP_CHANGE_AT;
    else if (roll < 90) op = OP_REPLACE_ALL;
    else if (roll < 94) op = OP_DELETE_ALL;
    else if (roll < 96) op = OP_CLEAR;
    else if (roll < 98) op = OP_FILL;
    else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    // positions mostly near the live range, sometimes anywhere
    pos_pick = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 63)) :
               int'($urandom_range(0, cap_now));
    send_request(op, pos_pick[POS_BITS-1:0], pick_value(), pick_value());
  endtask

  // one capacity setting with a random request mix
  task automatic run_phase(input int cap, input int n, input bit idle, input bit stall);
    set_capacity(cap);
    idle_on = idle;
    for (int k = 0; k < n; k++) begin
      if (stall && k == n / 2) hold_long = 1'b1;
      send_random_item();
    end
  endtask

  // result side: random hold-offs, now and then a long one
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int k;
      if (hold_long) begin
        k         = LONG_HOLD;
        hold_long = 1'b0;
        holds_done++;
      end else begin
        k = idle_on ? int'($urandom_range(0, 3)) : 0;
      end
      if (k > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // stimulus and verdict
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_APPEND;
    req_ch.position    <= '0;
    req_ch.value       <= '0;
    req_ch.replacement <= '0;
    idle_on            = 1'b1;
    hold_long          = 1'b0;
    cap_now            = DEPTH_DEF;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, bad positions, no match, full list
    send_request(OP_FIND_FIRST, 0, 0, 0);
    send_request(OP_REMOVE_LAST, 0, 0, 0);
    send_request(OP_DELETE_AT, 0, 0, 0);
    send_request(OP_REPLACE_ALL, 0, 0, 1);
    send_request(OP_APPEND, 0, 32'h7fff_ffff, 0);
    send_request(OP_PREPEND, 0, 32'h8000_0000, 0);
    send_request(OP_INSERT, 1, 32'hffff_ffff, 0);
    send_request(OP_INSERT, 4, 32'h1234_5678, 0);
    send_request(OP_INSERT, 3, 0, 0);
    send_request(OP_READ_AT, 0, 0, 0);
    send_request(OP_READ_AT, 4, 0, 0);
    send_request(OP_FIND_LAST, 0, 32'h7fff_ffff, 0);
    send_request(OP_FIND_FIRST, 0, 32'h0001_2345, 0);
    send_request(OP_CHANGE_AT, 1, 0, 0);
    send_request(OP_REPLACE_ALL, 0, 0, 5);
    send_request(OP_DELETE_ALL, 0, 5, 0);
    send_request(OP_DELETE_ALL, 0, 99, 0);
    send_request(OP_SPARE_A, 63, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_SPARE_B, 0, 0, 0);
    send_request(OP_FILL, 0, 32'hffff_ffff, 0);
    send_request(OP_APPEND, 0, 1, 0);
    send_request(OP_INSERT, 63, 1, 0);
    send_request(OP_DELETE_AT, 31, 0, 0);
    send_request(OP_REMOVE_FIRST, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0);

    // random phases over the capacity range, including out-of-range settings
    run_phase(32, 100, 1'b1, 1'b0);
    run_phase(1, 40, 1'b1, 1'b1);
    run_phase(0, 30, 1'b0, 1'b0);
    run_phase(63, 70, 1'b1, 1'b0);
    // full list, then capacity lowered below its length
    send_request(OP_FILL, 0, pick_value(), 0);
    run_phase(5, 40, 1'b1, 1'b0);
    run_phase(17, 60, 1'b0, 1'b1);
    run_phase(32, 80, 1'b1, 1'b1);
    run_phase(8, 50, 1'b1, 1'b0);
    run_phase(40, 70, 1'b0, 1'b0);
    run_phase(2, 40, 1'b1, 1'b0);
    run_phase(31, 60, 1'b1, 1'b1);
    run_phase(12, 50, 1'b1, 1'b0);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("run covered %0d requests over %0d capacity writes, %0d long result stalls",
             items_sent, cfg_writes, holds_done);
    $display("%0d results compared field by field, %0d failures, %0d left outstanding",
             result_count, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS array_list_engine_top");
    end else begin
      $display("FAIL array_list_engine_top");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("FAIL array_list_engine_top");
    $finish;
  end

endmodule

/* filelist.f */
sv/ale_pkg.sv
sv/ale_if.sv
sv/ale_store.sv
sv/ale_ctrl.sv
sv/array_list_engine_top.sv
sim/ale_list_checker.sv
sim/array_list_engine_top_tb.sv
